// ----- hdl/tcce_pkg.sv -----
// shared types, codes and constants of the text console cursor engine
package tcce_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // blank cell contents
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    // register port geometry
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index (paddr[2])
    localparam logic REG_TEXT_ATTR = 1'b0;

    // command kinds
    typedef enum logic [3:0] {
        K_PUT      = 4'd0,
        K_NEWLINE  = 4'd1,
        K_LEFT     = 4'd2,
        K_RIGHT    = 4'd3,
        K_UP       = 4'd4,
        K_DOWN     = 4'd5,
        K_BS       = 4'd6,
        K_CLR_ALL  = 4'd7,
        K_CLR_FROM = 4'd8,
        K_CLR_TO   = 4'd9,
        K_GOTO     = 4'd10,
        K_READ     = 4'd11
    } kind_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_LEFT1,
        S_LEFT2,
        S_CLR_SET,
        S_FILL,
        S_SCR_PRIME,
        S_SCROLL,
        S_READ,
        S_RCAP,
        S_DONE
    } state_t;

    // one command as taken from the input channel
    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_code;
        logic [6:0] target_x;
        logic [4:0] target_y;
    } cmd_t;

    // one result, cursor_x in the lowest bits
    typedef struct packed {
        logic [7:0]  cell_attr;
        logic [7:0]  cell_char;
        logic [10:0] cursor_position;
        logic [4:0]  cursor_y;
        logic [6:0]  cursor_x;
    } result_t;

endpackage

// ----- hdl/text_console_cursor_engine_top.sv -----
// Text console cursor engine, top level.
// Commands arrive on the s_ stream, one beat per command; s_tuser holds the
// kind, s_tdata the character and target coordinates. Every command gives
// exactly one result beat on the m_ stream: cursor column, row and linear
// position after the command, plus the cell read by a read command.
// The attribute byte for written and blanked cells lives in the register at
// byte address 0 of the APB port; write it while no command is in flight.
// Cursor moves, goto and unknown kinds touch no cell; put writes one cell,
// read reads one, backspace steps left, writes and steps left again. Clears
// write each cell of their range; a scroll (newline, down, right or put past
// the bottom row) copies each row up by one and blanks the bottom row. s_tready
// is high only while the sequencer is idle, which it reaches as the result is
// handed over, so one command is in work at a time and a new one is taken only
// once the result of the last has been handed over.
// After reset a clearing pass writes a blank with attribute 07 to every
// cell, during which s_tready stays low; the cursor starts at the top left.
// The result sits in an output register, so the next command is taken while
// it waits; a further result holds the sequencer until m_tready frees the
// register.
module text_console_cursor_engine_top #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,  // char_code[7:0], target_x[14:8], target_y[19:15]
    input  logic [3:0]                   s_tuser,  // kind[3:0]
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,  // cursor_x[6:0], cursor_y[11:7],
                                                   // cursor_position[22:12], cell_char[30:23],
                                                   // cell_attr[38:31]
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcce_pkg::PADDR_W-1:0] paddr,
    input  logic [tcce_pkg::PDATA_W-1:0] pwdata,
    output logic [tcce_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [7:0]        attr_reg;
    logic              m_tvalid_reg;
    tcce_pkg::result_t m_res_reg;
    tcce_pkg::cmd_t    cmd_in;
    tcce_pkg::result_t res;
    logic              res_valid;
    logic              out_free;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [15:0]       mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [15:0]       mem_rdata;
    logic [RW-1:0]     au_row;
    logic [CW-1:0]     au_col;
    logic [AW-1:0]     au_idx;
    logic              attr_sel;

    // unpack the input beat
    assign cmd_in.kind      = tcce_pkg::kind_t'(s_tuser);
    assign cmd_in.char_code = s_tdata[7:0];
    assign cmd_in.target_x  = s_tdata[14:8];
    assign cmd_in.target_y  = s_tdata[19:15];

    // register port
    assign pready   = 1'b1;
    assign attr_sel = (paddr[tcce_pkg::PADDR_W-1:2] == tcce_pkg::REG_TEXT_ATTR);
    assign prdata   = attr_sel ? tcce_pkg::PDATA_W'(attr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= tcce_pkg::RESET_ATTR;
        end else if (psel && penable && pwrite && pready && attr_sel) begin
            attr_reg <= pwdata[7:0];
        end
    end

    // output register
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    tcce_addr_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_addr (
        .row (au_row),
        .col (au_col),
        .idx (au_idx)
    );

    tcce_cell_ram #(
        .DEPTH (CELLS)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcce_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd_in    (cmd_in),
        .cmd_ready (s_tready),
        .text_attr (attr_reg),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .au_row    (au_row),
        .au_col    (au_col),
        .au_idx    (au_idx)
    );

endmodule

// ----- hdl/tcce_addr_unit.sv -----
// shared row/column to linear cell index unit
module tcce_addr_unit #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
    input  logic [$clog2(ROWS)-1:0]         row,
    input  logic [$clog2(COLUMNS)-1:0]      col,
    output logic [$clog2(COLUMNS*ROWS)-1:0] idx
);

    localparam int AW = $clog2(COLUMNS*ROWS);

    // index = row * columns + column
    assign idx = AW'(row) * AW'(COLUMNS) + AW'(col);

endmodule

// ----- hdl/tcce_cell_ram.sv -----
// screen cell store: one write port, one registered read port
module tcce_cell_ram #(
    parameter int DEPTH = tcce_pkg::DEF_COLUMNS * tcce_pkg::DEF_ROWS
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [15:0]              wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [15:0]              rdata
);

    logic [15:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/tcce_engine.sv -----
// command sequencer: cursor, sweep counter and cell store access
module tcce_engine #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cmd_valid,
    input  tcce_pkg::cmd_t                      cmd_in,
    output logic                                cmd_ready,
    input  logic [7:0]                          text_attr,
    input  logic                                out_free,
    output logic                                res_valid,
    output tcce_pkg::result_t                   res,
    output logic                                mem_we,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     mem_waddr,
    output logic [15:0]                         mem_wdata,
    output logic [$clog2(COLUMNS*ROWS)-1:0]     mem_raddr,
    input  logic [15:0]                         mem_rdata,
    output logic [$clog2(ROWS)-1:0]             au_row,
    output logic [$clog2(COLUMNS)-1:0]          au_col,
    input  logic [$clog2(COLUMNS*ROWS)-1:0]     au_idx
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW0 = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW:0]   CELLS_W   = (AW+1)'(CELLS);
    localparam logic [AW:0]   ROW_STEP  = (AW+1)'(COLUMNS + 1);

    tcce_pkg::state_t state_reg, state_next;
    tcce_pkg::cmd_t   cmd_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] last_reg, last_next;
    logic [CW-1:0] tx_reg;
    logic [RW-1:0] ty_reg;
    logic [7:0]    cchar_reg, cchar_next;
    logic [7:0]    cattr_reg, cattr_next;

    logic          accept;
    logic [CW-1:0] tx_sat;
    logic [RW-1:0] ty_sat;
    logic [AW:0]   scr_rd;
    logic          put_wrap;
    logic          row_bottom;
    logic [15:0]   blank;

    assign accept     = cmd_valid && (state_reg == tcce_pkg::S_IDLE);
    assign cmd_ready  = (state_reg == tcce_pkg::S_IDLE);
    assign row_bottom = (row_reg == ROW_LAST);
    assign put_wrap   = (col_reg == COL_LAST);
    assign blank      = {text_attr, tcce_pkg::BLANK_CHAR};
    assign scr_rd     = (AW+1)'(cnt_reg) + ROW_STEP;

    // saturate requested coordinates to the screen
    assign tx_sat = (9'(cmd_in.target_x) >= 9'(COLUMNS)) ? COL_LAST : CW'(cmd_in.target_x);
    assign ty_sat = (7'(cmd_in.target_y) >= 7'(ROWS)) ? ROW_LAST : RW'(cmd_in.target_y);

    // shared index unit: target cell for reads, cursor otherwise
    assign au_row = (state_reg == tcce_pkg::S_READ) ? ty_reg : row_reg;
    assign au_col = (state_reg == tcce_pkg::S_READ) ? tx_reg : col_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcce_pkg::S_INIT: begin
                if (cnt_reg == CELL_LAST) state_next = tcce_pkg::S_IDLE;
            end
            tcce_pkg::S_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd_in.kind)
                        tcce_pkg::K_PUT:      state_next = tcce_pkg::S_PUT;
                        tcce_pkg::K_NEWLINE,
                        tcce_pkg::K_DOWN:     state_next = row_bottom ? tcce_pkg::S_SCR_PRIME
                                                                     : tcce_pkg::S_DONE;
                        tcce_pkg::K_RIGHT:    state_next = (put_wrap && row_bottom)
                                                           ? tcce_pkg::S_SCR_PRIME
                                                           : tcce_pkg::S_DONE;
                        tcce_pkg::K_BS:       state_next = tcce_pkg::S_LEFT1;
                        tcce_pkg::K_CLR_ALL,
                        tcce_pkg::K_CLR_FROM,
                        tcce_pkg::K_CLR_TO:   state_next = tcce_pkg::S_CLR_SET;
                        tcce_pkg::K_READ:     state_next = tcce_pkg::S_READ;
                        default:              state_next = tcce_pkg::S_DONE;
                    endcase
                end
            end
            tcce_pkg::S_LEFT1:   state_next = tcce_pkg::S_PUT;
            tcce_pkg::S_PUT: begin
                if (put_wrap && row_bottom) begin
                    state_next = tcce_pkg::S_SCR_PRIME;
                end else if (cmd_reg.kind == tcce_pkg::K_BS) begin
                    state_next = tcce_pkg::S_LEFT2;
                end else begin
                    state_next = tcce_pkg::S_DONE;
                end
            end
            tcce_pkg::S_LEFT2:   state_next = tcce_pkg::S_DONE;
            tcce_pkg::S_CLR_SET: state_next = tcce_pkg::S_FILL;
            tcce_pkg::S_FILL: begin
                if (cnt_reg == last_reg) state_next = tcce_pkg::S_DONE;
            end
            tcce_pkg::S_SCR_PRIME: state_next = tcce_pkg::S_SCROLL;
            tcce_pkg::S_SCROLL: begin
                if (cnt_reg == CELL_LAST) begin
                    state_next = (cmd_reg.kind == tcce_pkg::K_BS) ? tcce_pkg::S_LEFT2
                                                                 : tcce_pkg::S_DONE;
                end
            end
            tcce_pkg::S_READ:    state_next = tcce_pkg::S_RCAP;
            tcce_pkg::S_RCAP:    state_next = tcce_pkg::S_DONE;
            tcce_pkg::S_DONE: begin
                if (out_free) state_next = tcce_pkg::S_IDLE;
            end
            default:             state_next = tcce_pkg::S_INIT;
        endcase
    end

    // cursor, counters and store access
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        cchar_next = cchar_reg;
        cattr_next = cattr_reg;
        mem_we     = 1'b0;
        mem_waddr  = cnt_reg;
        mem_wdata  = blank;
        mem_raddr  = au_idx;
        res_valid  = 1'b0;
        unique case (state_reg)
            tcce_pkg::S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {tcce_pkg::RESET_ATTR, tcce_pkg::BLANK_CHAR};
                cnt_next  = cnt_reg + AW'(1);
            end
            tcce_pkg::S_IDLE: begin
                if (accept) begin
                    cchar_next = '0;
                    cattr_next = '0;
                    unique case (cmd_in.kind)
                        tcce_pkg::K_NEWLINE: begin
                            col_next = '0;
                            if (!row_bottom) row_next = row_reg + RW'(1);
                        end
                        tcce_pkg::K_LEFT: begin
                            if (col_reg == '0) begin
                                col_next = COL_LAST;
                                if (row_reg != '0) row_next = row_reg - RW'(1);
                            end else begin
                                col_next = col_reg - CW'(1);
                            end
                        end
                        tcce_pkg::K_RIGHT: begin
                            if (put_wrap) begin
                                col_next = '0;
                                if (!row_bottom) row_next = row_reg + RW'(1);
                            end else begin
                                col_next = col_reg + CW'(1);
                            end
                        end
                        tcce_pkg::K_UP: begin
                            if (row_reg != '0) row_next = row_reg - RW'(1);
                        end
                        tcce_pkg::K_DOWN: begin
                            if (!row_bottom) row_next = row_reg + RW'(1);
                        end
                        tcce_pkg::K_GOTO: begin
                            col_next = tx_sat;
                            row_next = ty_sat;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tcce_pkg::S_LEFT1, tcce_pkg::S_LEFT2: begin
                if (col_reg == '0) begin
                    col_next = COL_LAST;
                    if (row_reg != '0) row_next = row_reg - RW'(1);
                end else begin
                    col_next = col_reg - CW'(1);
                end
            end
            tcce_pkg::S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = au_idx;
                mem_wdata = {text_attr, cmd_reg.char_code};
                if (put_wrap) begin
                    col_next = '0;
                    if (!row_bottom) row_next = row_reg + RW'(1);
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
            tcce_pkg::S_CLR_SET: begin
                cnt_next  = (cmd_reg.kind == tcce_pkg::K_CLR_FROM) ? au_idx : '0;
                last_next = (cmd_reg.kind == tcce_pkg::K_CLR_TO) ? au_idx : CELL_LAST;
            end
            tcce_pkg::S_FILL: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + AW'(1);
            end
            tcce_pkg::S_SCR_PRIME: begin
                mem_raddr = AW'(COLUMNS);
                cnt_next  = '0;
            end
            tcce_pkg::S_SCROLL: begin
                // copy from one row below, blank the last row
                mem_we    = 1'b1;
                mem_wdata = (cnt_reg < LAST_ROW0) ? mem_rdata : blank;
                mem_raddr = (scr_rd < CELLS_W) ? scr_rd[AW-1:0] : '0;
                cnt_next  = cnt_reg + AW'(1);
            end
            tcce_pkg::S_READ: begin
                mem_raddr = au_idx;
            end
            tcce_pkg::S_RCAP: begin
                cchar_next = mem_rdata[7:0];
                cattr_next = mem_rdata[15:8];
            end
            tcce_pkg::S_DONE: begin
                res_valid = out_free;
            end
            default: begin
            end
        endcase
    end

    // result fields
    assign res.cursor_x        = 7'(col_reg);
    assign res.cursor_y        = 5'(row_reg);
    assign res.cursor_position = 11'(au_idx);
    assign res.cell_char       = cchar_reg;
    assign res.cell_attr       = cattr_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcce_pkg::S_INIT;
            col_reg   <= '0;
            row_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        last_reg  <= last_next;
        cchar_reg <= cchar_next;
        cattr_reg <= cattr_next;
        if (accept) begin
            cmd_reg <= cmd_in;
            tx_reg  <= tx_sat;
            ty_reg  <= ty_sat;
        end
    end

endmodule

// ----- hdl/tcce_checker.sv -----
// port-level checks on the text console cursor engine, bound to the top level
module tcce_checker #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // the clearing pass keeps the input closed right after reset
    a_init_closed: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // one command in work at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready in the cycle after an accepted beat");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // linear position agrees with column and row
    a_position: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (COLUMNS > 128) ||
            (m_tdata[22:12] == 11'(32'(m_tdata[11:7]) * COLUMNS + 32'(m_tdata[6:0]))))
        else $error("cursor position does not match column and row");

endmodule

bind text_console_cursor_engine_top tcce_checker #(
    .COLUMNS (COLUMNS)
) u_tcce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
